// ----- src/pts_pkg.sv -----
// package for the process table scheduler: state codes, command codes,
// control struct shared between the sequencer and the slot cells
// no dependencies
package pts_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int SLOT_W    = 8;   // widest slot index the cells carry (up to 256 slots)
	localparam int PID_W     = 16;
	localparam int CNT_W     = 7;
	localparam int EXIT_W    = 32;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [PID_W-1:0]  pid_t;

	typedef enum logic [2:0] {
		ST_UNUSED  = 3'd0,
		ST_UNINIT  = 3'd1,
		ST_READY   = 3'd2,
		ST_RUNNING = 3'd3,
		ST_BLOCKED = 3'd4,
		ST_ZOMBIE  = 3'd5
	} status_t;

	localparam logic [3:0] CMD_ALLOC = 4'd0;
	localparam logic [3:0] CMD_FREE  = 4'd1;
	localparam logic [3:0] CMD_READY = 4'd2;
	localparam logic [3:0] CMD_LINK  = 4'd3;
	localparam logic [3:0] CMD_EXIT  = 4'd4;
	localparam logic [3:0] CMD_ZOMB  = 4'd5;
	localparam logic [3:0] CMD_SCHED = 4'd6;
	localparam logic [3:0] CMD_YIELD = 4'd7;
	localparam logic [3:0] CMD_BLOCK = 4'd8;

	localparam logic [1:0] OUT_OK      = 2'd0;
	localparam logic [1:0] OUT_NONE    = 2'd1;
	localparam logic [1:0] OUT_REFUSED = 2'd2;

	typedef enum logic [1:0] {
		SK_ALLOC,
		SK_ZOMB,
		SK_SCHED
	} search_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET_STATUS,
		OP_LINK,
		OP_EXIT,
		OP_CLAIM
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH,
		S_FINISH
	} state_t;

	typedef struct packed {
		cell_op_t op;
		search_t  kind;
		slot_t    tgt;
		slot_t    run;
		status_t  status;
		pid_t     pid;
		logic     tok_load;
		slot_t    tok_start;
		logic     tok_shift;
		logic     tok_kill;
	} cell_ctl_t;

endpackage

// ----- src/pts_if.sv -----
// channel interfaces for the process table scheduler: command in, result out
// no dependencies
interface pts_cmd_if;
	logic               valid;
	logic               ready;
	logic [3:0]         command;
	logic [5:0]         slot;
	logic signed [31:0] exit_value;

	modport source (output valid, command, slot, exit_value, input ready);
	modport sink (input valid, command, slot, exit_value, output ready);
endinterface

interface pts_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         outcome;
	logic [5:0]         result_slot;
	logic [15:0]        result_pid;
	logic signed [31:0] result_exit;
	logic [5:0]         current_slot;

	modport source (output valid, outcome, result_slot, result_pid, result_exit,
		current_slot, input ready);
	modport sink (input valid, outcome, result_slot, result_pid, result_exit,
		current_slot, output ready);
endinterface

// ----- src/process_table_scheduler_core.sv -----
// top level of the process table scheduler: sequencer, exit code memory,
// ring of slot cells; depends on pts_pkg, pts_if and pts_cell
//
// Free, make ready, link child and exit pass from acceptance through the
// execute and finish states to the result; alloc, find zombie (for a slot in
// range), schedule, yield and block pass a search token along the ring of slot
// cells one slot per cycle, visiting at most SLOTS slots (SLOTS-1 for alloc)
// before the finish state, where the result waits while the output register is
// still held by the receiver. One command is in work at a time; a new one is
// taken while the previous result still waits in the output register. Exit
// codes sit in a memory that is valid only for slots that have exited.
module process_table_scheduler_core #(
	parameter int SLOTS = pts_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	pts_cmd_if.sink   cmd,
	pts_res_if.source res
);
	import pts_pkg::*;

	localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW   = $clog2(SLOTS + 1);

	typedef logic [IDXW-1:0] idx_t;

	state_t            state_q, state_nx;
	logic [3:0]        cmd_q;
	logic [5:0]        slot_q;
	logic [EXIT_W-1:0] ev_q;
	idx_t              run_q, pos_q, run_nxt, pos_nxt;
	pid_t              pidc_q;
	logic [LW-1:0]     left_q;
	search_t           kind_q;
	logic [1:0]        res_out_q;
	logic [5:0]        res_slot_q;
	pid_t              res_pid_q;
	logic              res_zomb_q;
	logic [EXIT_W-1:0] exit_rd_q;
	logic [EXIT_W-1:0] exit_mem [SLOTS];

	logic              out_valid_q;
	logic [1:0]        out_outcome_q;
	logic [5:0]        out_slot_q, out_cur_q;
	pid_t              out_pid_q;
	logic [EXIT_W-1:0] out_exit_q;

	cell_ctl_t  ctl;
	logic [SLOTS-1:0] tok_vec, hit_vec;
	pid_t       cell_pid [SLOTS];
	pid_t       hit_pid;
	logic       any_hit, last, in_rng, out_free;
	slot_t      tgt8, run8;
	idx_t       tgt_idx;

	assign in_rng   = (32'(slot_q) < SLOTS);
	assign tgt8     = SLOT_W'(slot_q);
	assign run8     = SLOT_W'(run_q);
	assign tgt_idx  = IDXW'(slot_q);
	assign run_nxt  = (run_q == IDXW'(SLOTS - 1)) ? '0 : run_q + 1'b1;
	assign pos_nxt  = (pos_q == IDXW'(SLOTS - 1)) ? '0 : pos_q + 1'b1;
	assign last     = (left_q == LW'(1));
	assign any_hit  = |hit_vec;
	assign out_free = !out_valid_q || res.ready;

	// ring of slot cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		pts_cell #(.INDEX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_prev(tok_vec[(i + SLOTS - 1) % SLOTS]),
			.tok     (tok_vec[i]),
			.hit     (hit_vec[i]),
			.hit_pid (cell_pid[i])
		);
	end

	// pid of the hit cell, others drive zero
	always_comb begin
		hit_pid = '0;
		for (int i = 0; i < SLOTS; i++) hit_pid = hit_pid | cell_pid[i];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (cmd.valid) state_nx = S_EXEC;
			S_EXEC: begin
				if (cmd_q == CMD_ALLOC || cmd_q == CMD_SCHED || cmd_q == CMD_YIELD
						|| cmd_q == CMD_BLOCK || (cmd_q == CMD_ZOMB && in_rng))
					state_nx = S_SEARCH;
				else
					state_nx = S_FINISH;
			end
			S_SEARCH: if (any_hit || last) state_nx = S_FINISH;
			S_FINISH: if (out_free) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// cell control
	always_comb begin
		ctl           = '0;
		ctl.op        = OP_NONE;
		ctl.kind      = kind_q;
		ctl.tgt       = tgt8;
		ctl.run       = run8;
		ctl.status    = ST_UNUSED;
		ctl.pid       = pidc_q;
		ctl.tok_start = '0;
		case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_FREE: if (in_rng && tgt8 != run8) ctl.op = OP_SET_STATUS;
					CMD_READY: begin
						if (in_rng) ctl.op = OP_SET_STATUS;
						ctl.status = ST_READY;
					end
					CMD_LINK: if (in_rng) ctl.op = OP_LINK;
					CMD_EXIT: if (in_rng) ctl.op = OP_EXIT;
					CMD_ALLOC: begin
						ctl.tok_load  = 1'b1;
						ctl.tok_start = SLOT_W'(1);
					end
					CMD_ZOMB: ctl.tok_load = in_rng;
					CMD_SCHED: begin
						ctl.tok_load  = 1'b1;
						ctl.tok_start = SLOT_W'(run_nxt);
					end
					CMD_YIELD, CMD_BLOCK: begin
						ctl.op        = OP_SET_STATUS;
						ctl.tgt       = run8;
						ctl.status    = (cmd_q == CMD_YIELD) ? ST_READY : ST_BLOCKED;
						ctl.tok_load  = 1'b1;
						ctl.tok_start = SLOT_W'(run_nxt);
					end
					default: ;
				endcase
			end
			S_SEARCH: begin
				ctl.op        = OP_CLAIM;
				ctl.tok_shift = 1'b1;
				ctl.tok_kill  = any_hit || last;
			end
			default: ;
		endcase
	end

	assign cmd.ready = (state_q == S_IDLE);

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			run_q      <= '0;
			pidc_q     <= PID_W'(1);
			kind_q     <= SK_SCHED;
			left_q     <= '0;
			pos_q      <= '0;
			res_out_q  <= OUT_OK;
			res_zomb_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				S_EXEC: begin
					res_out_q  <= OUT_OK;
					res_zomb_q <= 1'b0;
					left_q     <= LW'(SLOTS);
					case (cmd_q)
						CMD_ALLOC: begin
							kind_q <= SK_ALLOC;
							pos_q  <= IDXW'(1);
							left_q <= LW'(SLOTS - 1);
						end
						CMD_FREE: begin
							if (!in_rng) res_out_q <= OUT_NONE;
							else if (tgt8 == run8) res_out_q <= OUT_REFUSED;
						end
						CMD_READY, CMD_LINK, CMD_EXIT: if (!in_rng) res_out_q <= OUT_NONE;
						CMD_ZOMB: begin
							kind_q <= SK_ZOMB;
							pos_q  <= '0;
							if (!in_rng) res_out_q <= OUT_NONE;
						end
						CMD_SCHED, CMD_YIELD, CMD_BLOCK: begin
							kind_q <= SK_SCHED;
							pos_q  <= run_nxt;
						end
						default: res_out_q <= OUT_NONE;
					endcase
				end
				S_SEARCH: begin
					pos_q  <= pos_nxt;
					left_q <= left_q - 1'b1;
					if (any_hit) begin
						if (kind_q == SK_ALLOC) pidc_q <= pidc_q + 1'b1;
						if (kind_q == SK_SCHED) run_q <= pos_q;
						res_zomb_q <= (kind_q == SK_ZOMB);
					end else if (last) begin
						res_out_q <= OUT_NONE;
					end
				end
				default: ;
			endcase
		end
	end

	// command capture and search result payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q  <= cmd.command;
			slot_q <= cmd.slot;
			ev_q   <= cmd.exit_value;
		end
		if (state_q == S_EXEC) begin
			res_slot_q <= '0;
			res_pid_q  <= '0;
		end else if (state_q == S_SEARCH && any_hit) begin
			res_slot_q <= 6'(pos_q);
			res_pid_q  <= (kind_q == SK_ALLOC) ? pidc_q : hit_pid;
		end
	end

	// exit code memory
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && cmd_q == CMD_EXIT && in_rng) exit_mem[tgt_idx] <= ev_q;
		if (state_q == S_SEARCH) exit_rd_q <= exit_mem[pos_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			out_outcome_q <= res_out_q;
			out_slot_q    <= (res_out_q == OUT_OK) ? res_slot_q : '0;
			out_pid_q     <= (res_out_q == OUT_OK) ? res_pid_q : '0;
			out_exit_q    <= (res_out_q == OUT_OK && res_zomb_q) ? exit_rd_q : '0;
			out_cur_q     <= 6'(run_q);
		end
	end

	assign res.valid        = out_valid_q;
	assign res.outcome      = out_outcome_q;
	assign res.result_slot  = out_slot_q;
	assign res.result_pid   = out_pid_q;
	assign res.result_exit  = out_exit_q;
	assign res.current_slot = out_cur_q;

	// at most one search token on the ring
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec)) else $error("more than one search token");

	// no token outside a search
	a_tok_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FINISH) |-> (tok_vec == '0))
		else $error("stray search token");

	// a hit in a schedule search moves the running slot there
	a_sched_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && any_hit && kind_q == SK_SCHED) |=> (run_q == $past(pos_q)))
		else $error("running slot not updated");

	// outcome code is always a defined one
	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_outcome_q != 2'd3)) else $error("bad outcome");

endmodule

// ----- src/pts_cell.sv -----
// one process slot: status, pid, parent link, child count and search token
// depends on pts_pkg
module pts_cell #(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pts_pkg::cell_ctl_t ctl,
	input  logic              tok_prev,
	output logic              tok,
	output logic              hit,
	output pts_pkg::pid_t     hit_pid
);
	import pts_pkg::*;

	localparam slot_t ME = SLOT_W'(INDEX);

	status_t          status_q;
	pid_t             pid_q;
	logic             has_par_q;
	slot_t            par_q;
	logic [CNT_W-1:0] cnt_q;
	logic             tok_q;
	logic             match;

	// slot qualifies for the running search
	always_comb begin
		case (ctl.kind)
			SK_ALLOC: match = (status_q == ST_UNUSED);
			SK_SCHED: match = (status_q == ST_READY);
			SK_ZOMB:  match = has_par_q && (par_q == ctl.tgt) && (status_q == ST_ZOMBIE);
			default:  match = 1'b0;
		endcase
	end

	assign tok     = tok_q;
	assign hit     = tok_q & match;
	assign hit_pid = hit ? pid_q : '0;

	// search token handed along the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.tok_load) begin
			tok_q <= (ctl.tok_start == ME);
		end else if (ctl.tok_kill) begin
			tok_q <= 1'b0;
		end else if (ctl.tok_shift) begin
			tok_q <= tok_prev;
		end
	end

	// slot state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= (INDEX == 0) ? ST_RUNNING : ST_UNUSED;
			pid_q     <= '0;
			has_par_q <= 1'b0;
			par_q     <= '0;
			cnt_q     <= '0;
		end else begin
			case (ctl.op)
				OP_SET_STATUS: begin
					if (ctl.tgt == ME) status_q <= ctl.status;
				end
				OP_LINK: begin
					if (ctl.tgt == ME) begin
						has_par_q <= 1'b1;
						par_q     <= ctl.run;
					end
					if (ctl.run == ME && cnt_q != '1) cnt_q <= cnt_q + 1'b1;
				end
				OP_EXIT: begin
					if (ctl.tgt == ME) status_q <= ST_ZOMBIE;
					// orphan the children of the exiting slot
					if (has_par_q && par_q == ctl.tgt) begin
						has_par_q <= 1'b0;
						par_q     <= '0;
					end
				end
				OP_CLAIM: begin
					if (hit) begin
						if (ctl.kind == SK_ALLOC) begin
							pid_q     <= ctl.pid;
							status_q  <= ST_UNINIT;
							has_par_q <= 1'b0;
							par_q     <= '0;
							cnt_q     <= '0;
						end else if (ctl.kind == SK_SCHED) begin
							status_q <= ST_RUNNING;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
